// File: rtl/hsfe_pkg.sv
// Package of the header sync frame extractor: sync pattern, defaults and tail match.
`default_nettype none
package hsfe_pkg;

  localparam int unsigned DefFrameBytes = 30;
  localparam int unsigned HdrLen = 4;

  localparam logic [7:0] SyncB0 = 8'hAA;
  localparam logic [7:0] SyncB1 = 8'hFF;
  localparam logic [7:0] SyncB2 = 8'h03;
  localparam logic [7:0] SyncB3 = 8'h00;

  localparam logic [7:0] SyncPattern [HdrLen] = '{SyncB0, SyncB1, SyncB2, SyncB3};

  typedef struct packed {
    logic       done;
    logic [1:0] keep;
  } rd_stat_t;

  function automatic logic [1:0] tail_keep(input logic [7:0] b2, input logic [7:0] b1,
                                           input logic [7:0] b0);
    logic [1:0] k;
    if (b2 == SyncB0 && b1 == SyncB1 && b0 == SyncB2) begin
      k = 2'd3;
    end else if (b1 == SyncB0 && b0 == SyncB1) begin
      k = 2'd2;
    end else if (b0 == SyncB0) begin
      k = 2'd1;
    end else begin
      k = 2'd0;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// File: rtl/hsfe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hsfe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 30,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/hsfe_reader.sv
// Frame dump reader: sweeps the frame store, drives the output register, finds the tail match.
`default_nettype none
module hsfe_reader import hsfe_pkg::*; #(
  parameter int unsigned FrameBytes = DefFrameBytes,
  localparam int unsigned AddrW = $clog2(FrameBytes)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  re_o,
  output logic      [AddrW-1:0] raddr_o,
  input  wire logic [7:0]       rdata_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [7:0]       out_byte_o,
  output logic                  out_last_o,
  output rd_stat_t              stat_o
);

  logic             active_q, active_d;
  logic [AddrW-1:0] raddr_q, raddr_d;
  logic             pend_q, pend_d;
  logic             pend_last_q, pend_last_d;
  logic             out_valid_q, out_valid_d;
  logic             out_last_q, out_last_d;
  logic [7:0]       out_byte_q;
  logic [7:0]       tail1_q, tail0_q;
  logic             consume;
  logic             issue;
  logic             is_last_addr;

  assign consume      = pend_q && (!out_valid_q || !out_stall_i);
  assign issue        = active_q && (!pend_q || consume);
  assign is_last_addr = (raddr_q == AddrW'(FrameBytes - 1));

  always_comb begin
    active_d    = active_q;
    raddr_d     = raddr_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    if (start_i) begin
      active_d = 1'b1;
      raddr_d  = '0;
    end else if (issue) begin
      raddr_d = raddr_q + AddrW'(1);
      if (is_last_addr) begin
        active_d = 1'b0;
      end
    end
    if (issue) begin
      pend_d      = 1'b1;
      pend_last_d = is_last_addr;
    end else if (consume) begin
      pend_d = 1'b0;
    end
    if (consume) begin
      out_valid_d = 1'b1;
      out_last_d  = pend_last_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      raddr_q     <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      active_q    <= active_d;
      raddr_q     <= raddr_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      out_byte_q <= rdata_i;
      tail1_q    <= tail0_q;
      tail0_q    <= rdata_i;
    end
  end

  assign re_o        = issue;
  assign raddr_o     = raddr_q;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign stat_o.done = consume && pend_last_q;
  assign stat_o.keep = tail_keep(tail1_q, tail0_q, rdata_i);

  a_no_read_over_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !consume |-> !re_o)
    else $error("read issued while read data is still unconsumed");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !active_q && !pend_q)
    else $error("dump started while previous dump still running");

  a_last_beat_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |=> out_valid_q && out_last_q)
    else $error("final frame beat not marked as last");

endmodule
`default_nettype wire

// File: rtl/header_sync_frame_extractor_core.sv
// Top level of the header sync frame extractor: hunt and fill control around the frame store.
//
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_byte_i
// out      output     out_valid_o / out_stall_i frame_byte_o, frame_last_o
//
// Input beats are taken without stall while the header is hunted and the frame is filled.
// The beat that completes a frame starts a dump: FrameBytes reads of the frame store, one per
// cycle while the output is not stalled, and the input stalls until the dump is done.
// The store's single read port sets that read rate; each output stall holds back the reads.
// Reset clears the fill count and the control state; the store itself is not cleared.
// The header prefix kept for the next frame already sits at the front of the store.
`default_nettype none
module header_sync_frame_extractor_core import hsfe_pkg::*; #(
  parameter int unsigned FrameBytes = DefFrameBytes,
  localparam int unsigned AddrW = $clog2(FrameBytes)
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] frame_byte_o,
  output logic            frame_last_o
);

  typedef enum logic [1:0] {
    StAccept = 2'b01,
    StDump   = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] fill_q, fill_d;
  logic             accept;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic             start;
  logic             re;
  logic [AddrW-1:0] raddr;
  logic [7:0]       rdata;
  rd_stat_t         stat;

  assign in_stall_o = (state_q != StAccept);
  assign accept     = in_valid_i && (state_q == StAccept);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    we      = 1'b0;
    waddr   = fill_q;
    start   = 1'b0;
    if (accept) begin
      if (fill_q < AddrW'(HdrLen)) begin
        if (in_byte_i == SyncPattern[fill_q[1:0]]) begin
          we     = 1'b1;
          fill_d = fill_q + AddrW'(1);
        end else if (in_byte_i == SyncB0) begin
          we     = 1'b1;
          waddr  = '0;
          fill_d = AddrW'(1);
        end else begin
          fill_d = '0;
        end
      end else begin
        we = 1'b1;
        if (fill_q == AddrW'(FrameBytes - 1)) begin
          state_d = StDump;
          start   = 1'b1;
        end else begin
          fill_d = fill_q + AddrW'(1);
        end
      end
    end
    if (stat.done) begin
      fill_d  = AddrW'(stat.keep);
      state_d = StAccept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StAccept;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  hsfe_ram #(
    .Width(8),
    .Depth(FrameBytes)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(in_byte_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  hsfe_reader #(
    .FrameBytes(FrameBytes)
  ) u_reader (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (frame_byte_o),
    .out_last_o (frame_last_o),
    .stat_o     (stat)
  );

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= AddrW'(FrameBytes - 1))
    else $error("fill count out of range");

  a_no_write_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDump |-> !we)
    else $error("frame store written during dump");

  a_done_only_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> state_q == StDump)
    else $error("dump completion outside dump");

  a_start_enters_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> state_q == StDump)
    else $error("frame completion did not enter dump");

endmodule
`default_nettype wire
